@@ design/tanc_pkg.sv @@
package tanc_pkg;

    // Coordinate format
    localparam int COORD_W   = 32;
    localparam int FRAC_BITS = 16;

    // Edge vectors, cross products and their magnitudes
    localparam int DIFF_W   = COORD_W + 1;
    localparam int PROD_W   = 2 * DIFF_W;
    localparam int NCR_W    = PROD_W + 1;
    localparam int MAG_W    = PROD_W;
    localparam int MAG_LO_W = 32;
    localparam int MAG_HI_W = MAG_W - MAG_LO_W;
    localparam int SQ_W     = 2 * MAG_W;
    localparam int NSQ_W    = SQ_W + 2;

    // Result formats
    localparam int AREA_W     = 52;
    localparam int AREA_SHIFT = 2 * FRAC_BITS + 2;
    localparam int PROJ_SHIFT = FRAC_BITS + 1;
    localparam int PROJ_W     = MAG_W - PROJ_SHIFT;
    localparam int NORM_W     = 32;
    localparam int NORM_FRAC  = 30;

    // Normal divider: quotient of n_i^2 * 2^(2*NORM_FRAC) by |n|^2
    localparam int QUO_W   = 2 * NORM_FRAC + 1;
    localparam int DIV_LAT = QUO_W;

    // Square root unit: one result bit per stage
    localparam int ISQ_K     = AREA_W;
    localparam int ISQ_RAD_W = 2 * ISQ_K;
    localparam int ISQ_REM_W = ISQ_K + 2;

    // Centroid: floor(sum / 3) through a reciprocal on an offset sum
    localparam int SUM_W     = COORD_W + 2;
    localparam int CEN_SHIFT = SUM_W + 1;
    localparam int CEN_PRD_W = 2 * SUM_W;
    localparam int CEN_Q_W   = COORD_W + 1;
    localparam logic [SUM_W-1:0] CEN_OFF   = SUM_W'(3) << (COORD_W - 1);
    localparam logic [SUM_W-1:0] CEN_RECIP = SUM_W'((64'd1 << CEN_SHIFT) / 3);
    localparam logic [COORD_W-1:0] CEN_FLIP = COORD_W'(1) << (COORD_W - 1);

    // Per-triangle data that rides beside the divider and root units
    typedef struct packed {
        logic [2:0]                neg;
        logic                      degen;
        logic [AREA_W-1:0]         proj;
        logic signed [COORD_W-1:0] cx;
        logic signed [COORD_W-1:0] cy;
        logic signed [COORD_W-1:0] cz;
    } t_side;

endpackage

@@ design/triangle_area_normal_centroid.sv @@
// Channel  | Direction | Handshake            | Payload
// request  | in        | start high, busy low | i_a_x .. i_c_z, signed Q16.16
// result   | out       | o_valid, one cycle   | areas Q36.16, center Q16.16,
//          |           |                      | unit normal Q2.30, degenerate
//
// One request enters per cycle; busy is always low.
// Each result passes through 6 front stages (edges, cross product, squares,
// squared length), 61 divider stages (one bit of n_i^2 * 2^60 / |n|^2 per
// stage), 52 square root stages and one output register. Synchronous
// active-low reset clears the valid bits only.
// The receiver cannot stall; results leave in request order.
module triangle_area_normal_centroid import tanc_pkg::*; (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      start,
    output logic                      busy,
    input  logic signed [COORD_W-1:0] i_a_x,
    input  logic signed [COORD_W-1:0] i_a_y,
    input  logic signed [COORD_W-1:0] i_a_z,
    input  logic signed [COORD_W-1:0] i_b_x,
    input  logic signed [COORD_W-1:0] i_b_y,
    input  logic signed [COORD_W-1:0] i_b_z,
    input  logic signed [COORD_W-1:0] i_c_x,
    input  logic signed [COORD_W-1:0] i_c_y,
    input  logic signed [COORD_W-1:0] i_c_z,
    output logic                      o_valid,
    output logic [AREA_W-1:0]         o_surface_area,
    output logic [AREA_W-1:0]         o_projected_area,
    output logic signed [COORD_W-1:0] o_center_x,
    output logic signed [COORD_W-1:0] o_center_y,
    output logic signed [COORD_W-1:0] o_center_z,
    output logic signed [NORM_W-1:0]  o_unit_nx,
    output logic signed [NORM_W-1:0]  o_unit_ny,
    output logic signed [NORM_W-1:0]  o_unit_nz,
    output logic                      o_degenerate
);

    localparam int SIDE_LAT = DIV_LAT + ISQ_K;

    assign busy = 1'b0;

    // Front end
    logic                 f_vld;
    logic [2:0][SQ_W-1:0] f_sq;
    logic [NSQ_W-1:0]     f_nsq;
    t_side                f_side;

    tanc_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (start),
        .i_a_x   (i_a_x),
        .i_a_y   (i_a_y),
        .i_a_z   (i_a_z),
        .i_b_x   (i_b_x),
        .i_b_y   (i_b_y),
        .i_b_z   (i_b_z),
        .i_c_x   (i_c_x),
        .i_c_y   (i_c_y),
        .i_c_z   (i_c_z),
        .o_vld   (f_vld),
        .o_sq    (f_sq),
        .o_nsq   (f_nsq),
        .o_side  (f_side)
    );

    // Surface area: isqrt(|n|^2 / 2^(2*FRAC_BITS+2)), then wait for the normals
    logic                 a_vld;
    logic [ISQ_K-1:0]     a_root;
    logic [ISQ_RAD_W-1:0] a_rad;
    logic [DIV_LAT-1:0]   r_a_vld;
    logic [AREA_W-1:0]    r_area [DIV_LAT];

    assign a_rad = ISQ_RAD_W'(f_nsq >> AREA_SHIFT);

    tanc_isqrt u_area_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (f_vld),
        .i_rad   (a_rad),
        .o_vld   (a_vld),
        .o_root  (a_root)
    );

    always_ff @(posedge i_clk) begin
        r_area[0] <= AREA_W'(a_root);
        for (int k = 1; k < DIV_LAT; k++) begin
            r_area[k] <= r_area[k-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= '0;
        end else begin
            r_a_vld <= {r_a_vld[DIV_LAT-2:0], a_vld};
        end
    end

    // Unit normal: isqrt(n_i^2 * 2^60 / |n|^2) per component
    logic [2:0]              d_vld;
    logic [2:0][QUO_W-1:0]   d_quo;
    logic [2:0]              s_vld;
    logic [2:0][ISQ_K-1:0]   s_root;

    for (genvar i = 0; i < 3; i++) begin : g_comp
        tanc_div u_div (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_vld   (f_vld),
            .i_num   (f_sq[i]),
            .i_den   (f_nsq),
            .o_vld   (d_vld[i]),
            .o_quo   (d_quo[i])
        );

        tanc_isqrt u_sqrt (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_vld   (d_vld[i]),
            .i_rad   (ISQ_RAD_W'(d_quo[i])),
            .o_vld   (s_vld[i]),
            .o_root  (s_root[i])
        );
    end

    // Hold signs, flag, projected area and centroid beside the long units
    t_side r_side [SIDE_LAT];

    always_ff @(posedge i_clk) begin
        r_side[0] <= f_side;
        for (int k = 1; k < SIDE_LAT; k++) begin
            r_side[k] <= r_side[k-1];
        end
    end

    // Apply signs, drop normals of a degenerate triangle
    t_side                        j_side;
    logic [2:0][NORM_W-1:0]       n_norm;

    assign j_side = r_side[SIDE_LAT-1];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            if (j_side.degen) begin
                n_norm[i] = '0;
            end else if (j_side.neg[i]) begin
                n_norm[i] = -NORM_W'(s_root[i]);
            end else begin
                n_norm[i] = NORM_W'(s_root[i]);
            end
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else begin
            o_valid <= s_vld[0];
        end
    end

    always_ff @(posedge i_clk) begin
        o_surface_area   <= r_area[DIV_LAT-1];
        o_projected_area <= j_side.proj;
        o_center_x       <= j_side.cx;
        o_center_y       <= j_side.cy;
        o_center_z       <= j_side.cz;
        o_unit_nx        <= n_norm[0];
        o_unit_ny        <= n_norm[1];
        o_unit_nz        <= n_norm[2];
        o_degenerate     <= j_side.degen;
    end

    // Area path and all three normal paths stay in step
    a_paths_aligned: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_a_vld[DIV_LAT-1] == s_vld[0]) && (s_vld[0] == s_vld[1])
            && (s_vld[1] == s_vld[2]))
        else $error("area and normal pipelines out of step");

    // A flat triangle has no area and no normal
    a_degen_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_degenerate) |-> (o_surface_area == '0
            && o_projected_area == '0 && o_unit_nx == '0
            && o_unit_ny == '0 && o_unit_nz == '0))
        else $error("degenerate triangle with nonzero area or normal");

    // A proper triangle has a nonzero normal
    a_normal_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_degenerate)
            |-> (o_unit_nx != '0 || o_unit_ny != '0 || o_unit_nz != '0))
        else $error("zero normal for a proper triangle");

    // Normal components never exceed one in Q2.30
    a_normal_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_unit_nx <= 32'sh4000_0000 && o_unit_nx >= -32'sh4000_0000
            && o_unit_ny <= 32'sh4000_0000 && o_unit_ny >= -32'sh4000_0000
            && o_unit_nz <= 32'sh4000_0000 && o_unit_nz >= -32'sh4000_0000))
        else $error("unit normal component out of range");

endmodule

@@ design/tanc_front.sv @@
module tanc_front import tanc_pkg::*; (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_vld,
    input  logic signed [COORD_W-1:0] i_a_x,
    input  logic signed [COORD_W-1:0] i_a_y,
    input  logic signed [COORD_W-1:0] i_a_z,
    input  logic signed [COORD_W-1:0] i_b_x,
    input  logic signed [COORD_W-1:0] i_b_y,
    input  logic signed [COORD_W-1:0] i_b_z,
    input  logic signed [COORD_W-1:0] i_c_x,
    input  logic signed [COORD_W-1:0] i_c_y,
    input  logic signed [COORD_W-1:0] i_c_z,
    output logic                      o_vld,
    output logic [2:0][SQ_W-1:0]      o_sq,
    output logic [NSQ_W-1:0]          o_nsq,
    output t_side                     o_side
);

    logic [5:0] r_vld;

    // Stage 1: edge vectors and offset coordinate sums
    logic signed [DIFF_W-1:0] r_ux, r_uy, r_uz, r_vx, r_vy, r_vz;
    logic [2:0][SUM_W-1:0]    r_sum;
    logic signed [SUM_W-1:0]  n_sx, n_sy, n_sz;

    always_comb begin
        n_sx = SUM_W'(i_a_x) + SUM_W'(i_b_x) + SUM_W'(i_c_x);
        n_sy = SUM_W'(i_a_y) + SUM_W'(i_b_y) + SUM_W'(i_c_y);
        n_sz = SUM_W'(i_a_z) + SUM_W'(i_b_z) + SUM_W'(i_c_z);
    end

    always_ff @(posedge i_clk) begin
        r_ux     <= DIFF_W'(i_b_x) - DIFF_W'(i_a_x);
        r_uy     <= DIFF_W'(i_b_y) - DIFF_W'(i_a_y);
        r_uz     <= DIFF_W'(i_b_z) - DIFF_W'(i_a_z);
        r_vx     <= DIFF_W'(i_c_x) - DIFF_W'(i_a_x);
        r_vy     <= DIFF_W'(i_c_y) - DIFF_W'(i_a_y);
        r_vz     <= DIFF_W'(i_c_z) - DIFF_W'(i_a_z);
        r_sum[0] <= $unsigned(n_sx) + CEN_OFF;
        r_sum[1] <= $unsigned(n_sy) + CEN_OFF;
        r_sum[2] <= $unsigned(n_sz) + CEN_OFF;
    end

    // Stage 2: cross product terms and reciprocal estimate of sum / 3
    logic signed [PROD_W-1:0] r_p_yz, r_p_zy, r_p_zx, r_p_xz, r_p_xy, r_p_yx;
    logic [2:0][SUM_W-1:0]    r_sum2;
    logic [2:0][CEN_Q_W-1:0]  r_q0;
    logic [2:0][CEN_PRD_W-1:0] n_prd;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n_prd[i] = CEN_PRD_W'(r_sum[i]) * CEN_PRD_W'(CEN_RECIP);
        end
    end

    always_ff @(posedge i_clk) begin
        r_p_yz <= r_uy * r_vz;
        r_p_zy <= r_uz * r_vy;
        r_p_zx <= r_uz * r_vx;
        r_p_xz <= r_ux * r_vz;
        r_p_xy <= r_ux * r_vy;
        r_p_yx <= r_uy * r_vx;
        r_sum2 <= r_sum;
        for (int i = 0; i < 3; i++) begin
            r_q0[i] <= n_prd[i][CEN_SHIFT +: CEN_Q_W];
        end
    end

    // Stage 3: cross product as sign and magnitude, centroid correction
    logic [2:0][MAG_W-1:0]     r_mag;
    logic [2:0]                r_neg;
    logic [2:0][COORD_W-1:0]   r_cen;
    logic signed [NCR_W-1:0]   n_n [3];
    logic [2:0][SUM_W-1:0]     n_rem;
    logic [2:0][CEN_Q_W-1:0]   n_q;

    always_comb begin
        n_n[0] = NCR_W'(r_p_yz) - NCR_W'(r_p_zy);
        n_n[1] = NCR_W'(r_p_zx) - NCR_W'(r_p_xz);
        n_n[2] = NCR_W'(r_p_xy) - NCR_W'(r_p_yx);
        for (int i = 0; i < 3; i++) begin
            n_rem[i] = r_sum2[i] - SUM_W'(r_q0[i]) * SUM_W'(3);
            n_q[i]   = r_q0[i] + CEN_Q_W'(n_rem[i] >= SUM_W'(3));
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < 3; i++) begin
            r_neg[i] <= n_n[i][NCR_W-1];
            r_mag[i] <= n_n[i][NCR_W-1] ? MAG_W'(-n_n[i]) : MAG_W'(n_n[i]);
            r_cen[i] <= n_q[i][COORD_W-1:0] ^ CEN_FLIP;
        end
    end

    // Stage 4: partial products of each square, projected area
    logic [2:0][2*MAG_HI_W-1:0]        r_hh;
    logic [2:0][MAG_HI_W+MAG_LO_W-1:0] r_hl;
    logic [2:0][2*MAG_LO_W-1:0]        r_ll;
    logic [2:0]                        r_neg4;
    logic [2:0][COORD_W-1:0]           r_cen4;
    logic [AREA_W-1:0]                 r_proj4;

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < 3; i++) begin
            r_hh[i] <= (2*MAG_HI_W)'(r_mag[i][MAG_W-1:MAG_LO_W])
                     * (2*MAG_HI_W)'(r_mag[i][MAG_W-1:MAG_LO_W]);
            r_hl[i] <= (MAG_HI_W+MAG_LO_W)'(r_mag[i][MAG_W-1:MAG_LO_W])
                     * (MAG_HI_W+MAG_LO_W)'(r_mag[i][MAG_LO_W-1:0]);
            r_ll[i] <= (2*MAG_LO_W)'(r_mag[i][MAG_LO_W-1:0])
                     * (2*MAG_LO_W)'(r_mag[i][MAG_LO_W-1:0]);
        end
        r_neg4  <= r_neg;
        r_cen4  <= r_cen;
        // the shifted magnitude is narrower than the area field: no clamp
        r_proj4 <= AREA_W'(r_mag[2][MAG_W-1:PROJ_SHIFT]);
    end

    // Stage 5: assemble the squares
    logic [2:0][SQ_W-1:0]    r_sq5;
    logic [2:0]              r_neg5;
    logic [2:0][COORD_W-1:0] r_cen5;
    logic [AREA_W-1:0]       r_proj5;

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < 3; i++) begin
            r_sq5[i] <= (SQ_W'(r_hh[i]) << (2 * MAG_LO_W))
                      + (SQ_W'(r_hl[i]) << (MAG_LO_W + 1))
                      + SQ_W'(r_ll[i]);
        end
        r_neg5  <= r_neg4;
        r_cen5  <= r_cen4;
        r_proj5 <= r_proj4;
    end

    // Stage 6: squared length and zero test
    logic [NSQ_W-1:0] n_nsq;

    always_comb begin
        n_nsq = NSQ_W'(r_sq5[0]) + NSQ_W'(r_sq5[1]) + NSQ_W'(r_sq5[2]);
    end

    always_ff @(posedge i_clk) begin
        o_sq         <= r_sq5;
        o_nsq        <= n_nsq;
        o_side.neg   <= r_neg5;
        o_side.degen <= (n_nsq == '0);
        o_side.proj  <= r_proj5;
        o_side.cx    <= r_cen5[0];
        o_side.cy    <= r_cen5[1];
        o_side.cz    <= r_cen5[2];
    end

    // Advance the valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[4:0], i_vld};
        end
    end

    assign o_vld = r_vld[5];

endmodule

@@ design/tanc_div.sv @@
module tanc_div import tanc_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_vld,
    input  logic [SQ_W-1:0]  i_num,
    input  logic [NSQ_W-1:0] i_den,
    output logic             o_vld,
    output logic [QUO_W-1:0] o_quo
);

    logic [DIV_LAT-1:0] r_vld;
    logic [NSQ_W-1:0]   r_rem [DIV_LAT];
    logic [NSQ_W-1:0]   r_den [DIV_LAT];
    logic [QUO_W-1:0]   r_quo [DIV_LAT];

    // First stage: top quotient bit, numerator never exceeds the divisor
    logic [NSQ_W-1:0] n_num0;
    logic             n_bit0;

    always_comb begin
        n_num0 = NSQ_W'(i_num);
        n_bit0 = (n_num0 >= i_den);
    end

    always_ff @(posedge i_clk) begin
        r_rem[0] <= n_bit0 ? n_num0 - i_den : n_num0;
        r_den[0] <= i_den;
        r_quo[0] <= QUO_W'(n_bit0);
    end

    // Remaining stages: shift, trial subtract, one quotient bit each
    for (genvar k = 1; k < DIV_LAT; k++) begin : g_stage
        logic [NSQ_W:0]   n_shift;
        logic [NSQ_W:0]   n_diff;
        logic             n_bit;

        always_comb begin
            n_shift = {r_rem[k-1], 1'b0};
            n_diff  = n_shift - {1'b0, r_den[k-1]};
            n_bit   = (n_shift >= {1'b0, r_den[k-1]});
        end

        always_ff @(posedge i_clk) begin
            r_rem[k] <= n_bit ? n_diff[NSQ_W-1:0] : n_shift[NSQ_W-1:0];
            r_den[k] <= r_den[k-1];
            r_quo[k] <= {r_quo[k-1][QUO_W-2:0], n_bit};
        end
    end

    // Advance the valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[DIV_LAT-2:0], i_vld};
        end
    end

    assign o_vld = r_vld[DIV_LAT-1];
    assign o_quo = r_quo[DIV_LAT-1];

    // Final remainder stays below a nonzero divisor
    a_rem_below_den: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vld[DIV_LAT-1] && r_den[DIV_LAT-1] != '0)
            |-> (r_rem[DIV_LAT-1] < r_den[DIV_LAT-1]))
        else $error("divider remainder not reduced");

endmodule

@@ design/tanc_isqrt.sv @@
module tanc_isqrt import tanc_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_vld,
    input  logic [ISQ_RAD_W-1:0] i_rad,
    output logic                 o_vld,
    output logic [ISQ_K-1:0]     o_root
);

    logic [ISQ_K-1:0]     r_vld;
    logic [ISQ_RAD_W-1:0] r_rad  [ISQ_K];
    logic [ISQ_REM_W-1:0] r_rem  [ISQ_K];
    logic [ISQ_K-1:0]     r_root [ISQ_K];

    // One root bit per stage, most significant pair first
    for (genvar k = 0; k < ISQ_K; k++) begin : g_stage
        localparam int PAIR = ISQ_K - 1 - k;

        logic [ISQ_RAD_W-1:0] n_rad_in;
        logic [ISQ_REM_W-1:0] n_rem_in;
        logic [ISQ_K-1:0]     n_root_in;
        logic [ISQ_REM_W-1:0] n_acc;
        logic [ISQ_REM_W-1:0] n_trial;
        logic                 n_bit;

        if (k == 0) begin : g_first
            assign n_rad_in  = i_rad;
            assign n_rem_in  = '0;
            assign n_root_in = '0;
        end else begin : g_next
            assign n_rad_in  = r_rad[k-1];
            assign n_rem_in  = r_rem[k-1];
            assign n_root_in = r_root[k-1];
        end

        always_comb begin
            n_acc   = {n_rem_in[ISQ_REM_W-3:0], n_rad_in[2*PAIR+1 -: 2]};
            n_trial = {n_root_in, 2'b01};
            n_bit   = (n_acc >= n_trial);
        end

        always_ff @(posedge i_clk) begin
            r_rad[k]  <= n_rad_in;
            r_rem[k]  <= n_bit ? n_acc - n_trial : n_acc;
            r_root[k] <= {n_root_in[ISQ_K-2:0], n_bit};
        end
    end

    // Advance the valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[ISQ_K-2:0], i_vld};
        end
    end

    assign o_vld  = r_vld[ISQ_K-1];
    assign o_root = r_root[ISQ_K-1];

endmodule
